FILE: design/apbm_pkg.sv
// Shared constants, types and helpers of the aligned pattern byte matcher.
package apbm_pkg;

	localparam int MAX_PATTERN_BYTES = 16;
	localparam int ADDRESS_BITS      = 48;
	localparam int CFG_INDEX_BITS    = 3;
	localparam int CFG_DATA_BITS     = 64;
	localparam int LEN_BITS          = 5;
	localparam int CELL_IDX_BITS     = $clog2(MAX_PATTERN_BYTES);

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_PATTERN_LOW    = 3'd0,
		CFG_PATTERN_HIGH   = 3'd1,
		CFG_PATTERN_LENGTH = 3'd2,
		CFG_ALIGNMENT_LOG2 = 3'd3,
		CFG_FOLD_CASE      = 3'd4
	} cfg_index_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

	typedef struct packed {
		logic valid;
		logic eq;
	} cell_stat_t;

	function automatic logic [7:0] fold_ascii(input logic [7:0] b, input logic en);
		logic [7:0] r;
		r = b;
		if (en && b >= 8'h41 && b <= 8'h5A) begin
			r = b + 8'h20;
		end
		return r;
	endfunction

endpackage

FILE: design/aligned_pattern_byte_matcher.sv
// Top level: config registers, shift chain of window cells, match stage and output register.
//
//  channel  direction  handshake            payload
//  in       sink       in_valid / in_stall  data_byte, byte_address, region_start
//  out      source     out_valid/out_stall  match_address, matched_low, matched_high
//  cfg      sink       cfg_we               cfg_index, cfg_data
//
// One byte per cycle while in_stall is low; a match appears on out once its byte has passed the
// window cells and the output register. The window cells compare in parallel in the cycle after the
// shift; the address subtract and alignment check share that cycle, then the result is registered.
// Reset clears fill bits, the pipeline and the output; config takes reset values.
// in_stall rises only when the match stage is full and the output register is stalled.
module aligned_pattern_byte_matcher (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [7:0]                             data_byte,
	input  logic [apbm_pkg::ADDRESS_BITS-1:0]      byte_address,
	input  logic                                   region_start,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [apbm_pkg::ADDRESS_BITS-1:0]      match_address,
	output logic [63:0]                            matched_low,
	output logic [63:0]                            matched_high,
	input  logic                                   cfg_we,
	input  logic [apbm_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [apbm_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
	import apbm_pkg::*;

	localparam int N = MAX_PATTERN_BYTES;

	logic [63:0]         pattern_low_q;
	logic [63:0]         pattern_high_q;
	logic [LEN_BITS-1:0] pattern_length_q;
	logic [3:0]          alignment_log2_q;
	logic                fold_case_q;

	logic                    accept;
	logic                    out_free;
	logic                    valid_s1;
	logic [ADDRESS_BITS-1:0] addr_s1;
	logic                    out_valid_q;
	logic [ADDRESS_BITS-1:0] match_address_q;
	logic [127:0]            matched_q;

	logic [7:0]       cell_byte [N];
	cell_stat_t       cell_stat [N];
	logic [7:0]       cell_pat  [N];
	logic [7:0]       pat_bytes [N];
	logic [N-1:0]     fill_vec;

	logic [LEN_BITS-1:0]      eff_len;
	logic [CELL_IDX_BITS-1:0] len_m1;
	logic                     all_ok;
	logic                     hit;
	logic [ADDRESS_BITS-1:0]  start_addr;
	logic [ADDRESS_BITS-1:0]  align_mask;
	logic [127:0]             matched_all;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
			pattern_length_q <= LEN_BITS'(1);
			alignment_log2_q <= '0;
			fold_case_q      <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_PATTERN_LOW:    pattern_low_q    <= cfg_data[63:0];
				CFG_PATTERN_HIGH:   pattern_high_q   <= cfg_data[63:0];
				CFG_PATTERN_LENGTH: pattern_length_q <= cfg_data[LEN_BITS-1:0];
				CFG_ALIGNMENT_LOG2: alignment_log2_q <= cfg_data[3:0];
				CFG_FOLD_CASE:      fold_case_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		eff_len = pattern_length_q;
		if (pattern_length_q == '0) begin
			eff_len = LEN_BITS'(1);
		end else if (pattern_length_q > LEN_BITS'(N)) begin
			eff_len = LEN_BITS'(N);
		end
		len_m1 = CELL_IDX_BITS'(eff_len - LEN_BITS'(1));
	end

	always_comb begin
		for (int k = 0; k < N; k++) begin
			if (k < 8) begin
				pat_bytes[k] = pattern_low_q[8*k +: 8];
			end else begin
				pat_bytes[k] = pattern_high_q[8*(k-8) +: 8];
			end
		end
		// cell j holds window byte j, which lines up with pattern byte len-1-j
		for (int j = 0; j < N; j++) begin
			cell_pat[j] = pat_bytes[CELL_IDX_BITS'(len_m1 - CELL_IDX_BITS'(j))];
		end
	end

	// ---------------- handshake ----------------
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !out_free;
	assign accept   = in_valid && !in_stall;

	// ---------------- window chain ----------------
	for (genvar j = 0; j < N; j++) begin : g_cell
		cell_ctrl_t ctrl;
		logic [7:0] sin;
		logic       vin;
		if (j == 0) begin : g_head
			assign sin = data_byte;
			assign vin = 1'b1;
			assign ctrl = '{shift: accept, clear: 1'b0};
		end else begin : g_body
			assign sin = cell_byte[j-1];
			assign vin = cell_stat[j-1].valid;
			assign ctrl = '{shift: accept, clear: region_start};
		end
		apbm_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl),
			.shift_in     (sin),
			.valid_in     (vin),
			.pattern_byte (cell_pat[j]),
			.fold_case    (fold_case_q),
			.byte_q       (cell_byte[j]),
			.stat         (cell_stat[j])
		);
		assign fill_vec[j] = cell_stat[j].valid;
	end

	// ---------------- match stage ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1 <= byte_address;
		end
	end

	always_comb begin
		all_ok = 1'b1;
		for (int j = 0; j < N; j++) begin
			if (CELL_IDX_BITS'(j) <= len_m1) begin
				all_ok = all_ok && cell_stat[j].eq;
			end
		end
		for (int k = 0; k < N; k++) begin
			if (CELL_IDX_BITS'(k) <= len_m1) begin
				matched_all[8*k +: 8] = cell_byte[CELL_IDX_BITS'(len_m1 - CELL_IDX_BITS'(k))];
			end else begin
				matched_all[8*k +: 8] = 8'h00;
			end
		end
		start_addr = addr_s1 - ADDRESS_BITS'(len_m1);
		align_mask = ~({ADDRESS_BITS{1'b1}} << alignment_log2_q);
		hit = valid_s1 && cell_stat[len_m1].valid && all_ok
			&& ((start_addr & align_mask) == '0);
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= hit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && hit) begin
			match_address_q <= start_addr;
			matched_q       <= matched_all;
		end
	end

	assign out_valid     = out_valid_q;
	assign match_address = match_address_q;
	assign matched_low   = matched_q[63:0];
	assign matched_high  = matched_q[127:64];

	// ---------------- checks ----------------
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked match stage");

	a_s1_load: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted request did not reach the match stage");

	a_region_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && region_start) |=> (fill_vec == N'(1)))
		else $error("region start did not empty the window");

	a_fill_thermo: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_vec & (fill_vec + N'(1))) == '0)
		else $error("window fill bits are not contiguous from the newest cell");

	a_hit_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(hit && out_free) |=> out_valid_q)
		else $error("match lost between stage and output register");

endmodule

FILE: design/apbm_cell.sv
// One window cell: holds a byte and its fill bit, compares against its pattern byte.
module apbm_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  apbm_pkg::cell_ctrl_t  ctrl,
	input  logic [7:0]            shift_in,
	input  logic                  valid_in,
	input  logic [7:0]            pattern_byte,
	input  logic                  fold_case,
	output logic [7:0]            byte_q,
	output apbm_pkg::cell_stat_t  stat
);
	import apbm_pkg::*;

	logic valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= valid_in && !ctrl.clear;
		end
	end

	// drop old region bytes on a region start
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			byte_q <= ctrl.clear ? 8'h00 : shift_in;
		end
	end

	always_comb begin
		stat.valid = valid_q;
		stat.eq    = (fold_ascii(byte_q, fold_case) == fold_ascii(pattern_byte, fold_case));
	end

endmodule
